// ===== src/tcsr_pkg.sv =====
// Shared types and constants for the two-choice sum reachability block.
`timescale 1ns / 1ps
`default_nettype none

package tcsr_pkg;

  localparam int VAL_W      = 10;
  localparam int ITEM_NUM_W = 6;
  localparam int APB_DW     = 32;
  localparam int APB_AW     = 3;

  // word index of the target_sum register (byte address 4*index)
  localparam logic REG_TARGET_SUM = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPLY,
    ST_CHECK,
    ST_TRACE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic apply;
    logic tb_init;
    logic tb_step;
    logic emit_step;
    logic emit_fail;
    logic new_set;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic fin;
    logic hit;
    logic k_zero;
    logic e_last;
  } sts_t;

endpackage

`default_nettype wire

// ===== src/tcsr_ctrl.sv =====
// Controller state machine: item update, traceback walk and result emission.
`timescale 1ns / 1ps
`default_nettype none

module tcsr_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic          final_item,
  input  tcsr_pkg::sts_t     sts,
  output tcsr_pkg::cmd_t     cmd,
  output logic               busy
);
  import tcsr_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.accept = 1'b1;
          if (!sts.full) begin
            state_nxt = ST_APPLY;
          end else if (final_item) begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = sts.fin ? ST_CHECK : ST_IDLE;
      end
      ST_CHECK: begin
        if (sts.hit) begin
          cmd.tb_init = 1'b1;
          state_nxt   = ST_TRACE;
        end else begin
          cmd.emit_fail = 1'b1;
          cmd.new_set   = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_TRACE: begin
        cmd.tb_step = 1'b1;
        if (sts.k_zero) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit_step = 1'b1;
        if (sts.e_last) begin
          cmd.new_set = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_apply_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_APPLY |=> state_r == ST_IDLE || state_r == ST_CHECK)
    else $error("apply did not return to idle or check");

  a_trace_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_TRACE && sts.k_zero |=> state_r == ST_EMIT)
    else $error("traceback did not move to emit after item zero");

  a_miss_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CHECK && !sts.hit |=> state_r == ST_IDLE)
    else $error("unreachable target did not end the set");

endmodule

`default_nettype wire

// ===== src/tcsr_datapath.sv =====
// Datapath: reachability row, shared shifter, row/value/choice stores, traceback.
`timescale 1ns / 1ps
`default_nettype none

module tcsr_datapath #(
  parameter int MAX_ITEMS = 64,
  parameter int SUM_BITS  = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  tcsr_pkg::cmd_t                       cmd,
  output tcsr_pkg::sts_t                       sts,
  input  wire logic [tcsr_pkg::VAL_W-1:0]      first_value,
  input  wire logic [tcsr_pkg::VAL_W-1:0]      second_value,
  input  wire logic                            final_item,
  input  wire logic [tcsr_pkg::VAL_W-1:0]      target_sum,
  output logic                                 out_strobe,
  output logic                                 out_feasible,
  output logic [tcsr_pkg::ITEM_NUM_W-1:0]      out_item_number,
  output logic                                 out_took_second,
  output logic                                 out_run_end
);
  import tcsr_pkg::*;

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int IW = (SUM_BITS > 1) ? $clog2(SUM_BITS) : 1;

  function automatic logic row_bit(input logic [SUM_BITS-1:0] row,
                                   input logic [VAL_W-1:0] s);
    logic hit;
    hit = 1'b0;
    if (32'(s) < SUM_BITS) begin
      hit = row[IW'(s)];
    end
    return hit;
  endfunction

  logic [SUM_BITS-1:0]   cur_row_r, cur_row_nxt;
  logic [SUM_BITS-1:0]   shift_r;
  logic [VAL_W-1:0]      second_r;
  logic                  fin_r, fin_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [AW-1:0]         k_r, k_nxt;
  logic [AW-1:0]         e_r, e_nxt;
  logic [VAL_W-1:0]      cursor_r, cursor_nxt;
  logic                  strobe_r, strobe_nxt;
  logic                  feas_r, feas_nxt;
  logic [ITEM_NUM_W-1:0] item_r, item_nxt;
  logic                  end_r, end_nxt;

  logic [SUM_BITS-1:0]   row_mem [MAX_ITEMS];
  logic [2*VAL_W-1:0]    val_mem [MAX_ITEMS];
  logic                  choice_mem [MAX_ITEMS];
  logic [SUM_BITS-1:0]   row_q;
  logic [2*VAL_W-1:0]    val_q;
  logic                  choice_q;

  logic [VAL_W-1:0]      sh_amt;
  logic [SUM_BITS-1:0]   sh_out;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         rd_addr;
  logic                  rd_en;
  logic [VAL_W-1:0]      va, vb, diff_a;
  logic                  take_first;
  logic [VAL_W-1:0]      trace_nxt;

  assign sh_amt = cmd.accept ? first_value : second_r;
  assign sh_out = cur_row_r << sh_amt;

  assign sts.full   = (count_r == CW'(MAX_ITEMS));
  assign sts.fin    = fin_r;
  assign sts.hit    = row_bit(cur_row_r, target_sum);
  assign sts.k_zero = (k_r == '0);
  assign sts.e_last = (CW'(e_r) == count_r - CW'(1));

  assign wr_addr = AW'(count_r);
  assign rd_addr = cmd.tb_init ? AW'(count_r - CW'(1)) : k_r - AW'(1);
  assign rd_en   = cmd.tb_init | (cmd.tb_step & ~sts.k_zero);

  // greedy traceback: prefer the first value when the remainder was reachable
  assign va         = val_q[VAL_W-1:0];
  assign vb         = val_q[2*VAL_W-1:VAL_W];
  assign diff_a     = cursor_r - va;
  assign take_first = (cursor_r >= va) && row_bit(row_q, diff_a);
  assign trace_nxt  = take_first ? diff_a :
                      ((cursor_r >= vb) ? cursor_r - vb : '0);

  always_comb begin
    cur_row_nxt = cur_row_r;
    fin_nxt     = fin_r;
    count_nxt   = count_r;
    k_nxt       = k_r;
    e_nxt       = e_r;
    cursor_nxt  = cursor_r;
    strobe_nxt  = 1'b0;
    feas_nxt    = feas_r;
    item_nxt    = item_r;
    end_nxt     = end_r;
    if (cmd.accept) begin
      fin_nxt = final_item;
    end
    if (cmd.apply) begin
      cur_row_nxt = shift_r | sh_out;
      count_nxt   = count_r + CW'(1);
    end
    if (cmd.tb_init) begin
      cursor_nxt = target_sum;
      k_nxt      = rd_addr;
    end
    if (cmd.tb_step) begin
      cursor_nxt = trace_nxt;
      k_nxt      = rd_addr;
    end
    if (cmd.emit_step) begin
      strobe_nxt = 1'b1;
      feas_nxt   = 1'b1;
      item_nxt   = ITEM_NUM_W'(e_r);
      end_nxt    = sts.e_last;
      e_nxt      = e_r + AW'(1);
    end
    if (cmd.emit_fail) begin
      strobe_nxt = 1'b1;
      feas_nxt   = 1'b0;
      item_nxt   = '0;
      end_nxt    = 1'b1;
    end
    if (cmd.new_set) begin
      cur_row_nxt = SUM_BITS'(1);
      fin_nxt     = 1'b0;
      count_nxt   = '0;
      cursor_nxt  = '0;
      e_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r <= SUM_BITS'(1);
      fin_r     <= 1'b0;
      count_r   <= '0;
      k_r       <= '0;
      e_r       <= '0;
      cursor_r  <= '0;
      strobe_r  <= 1'b0;
    end else begin
      cur_row_r <= cur_row_nxt;
      fin_r     <= fin_nxt;
      count_r   <= count_nxt;
      k_r       <= k_nxt;
      e_r       <= e_nxt;
      cursor_r  <= cursor_nxt;
      strobe_r  <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      shift_r  <= sh_out;
      second_r <= second_value;
    end
    feas_r <= feas_nxt;
    item_r <= item_nxt;
    end_r  <= end_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && !sts.full) begin
      row_mem[wr_addr] <= cur_row_r;
      val_mem[wr_addr] <= {second_value, first_value};
    end
    if (rd_en) begin
      row_q <= row_mem[rd_addr];
      val_q <= val_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tb_step) begin
      choice_mem[k_r] <= ~take_first;
    end
    if (cmd.emit_step) begin
      choice_q <= choice_mem[e_r];
    end else if (cmd.emit_fail) begin
      choice_q <= 1'b0;
    end
  end

  assign out_strobe      = strobe_r;
  assign out_feasible    = feas_r;
  assign out_item_number = item_r;
  assign out_took_second = choice_q;
  assign out_run_end     = end_r;

endmodule

`default_nettype wire

// ===== src/two_choice_sum_reachability.sv =====
// Top level: APB target register, controller and datapath of the sum reachability block.
//
//   channel  direction  handshake             payload
//   input    in         start & !busy         in_first_value, in_second_value, in_final_item
//   result   out        out_strobe (1 cycle)  out_feasible, out_item_number, out_took_second,
//                                             out_run_end
//   config   in         psel&penable&pwrite   paddr, pwdata, prdata (target_sum at 0x0)
//
// An item is accepted, then gets a second shifter pass; one past the store limit is only
// accepted. After the final item: a check state, then a traceback walk step per stored item
// (one row store read per cycle), then one result per cycle from the choice store.
// An unreachable target gives its single result the cycle after the check.
// Synchronous reset clears the row to sum zero, the item count and all control state;
// the stores need no clearing. Results cannot be held off by the receiver.
`timescale 1ns / 1ps
`default_nettype none

module two_choice_sum_reachability #(
  parameter int MAX_ITEMS = 64,
  parameter int SUM_BITS  = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [tcsr_pkg::VAL_W-1:0]      in_first_value,
  input  wire logic [tcsr_pkg::VAL_W-1:0]      in_second_value,
  input  wire logic                            in_final_item,
  output logic                                 out_strobe,
  output logic                                 out_feasible,
  output logic [tcsr_pkg::ITEM_NUM_W-1:0]      out_item_number,
  output logic                                 out_took_second,
  output logic                                 out_run_end,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [tcsr_pkg::APB_AW-1:0]     paddr,
  input  wire logic [tcsr_pkg::APB_DW-1:0]     pwdata,
  output logic [tcsr_pkg::APB_DW-1:0]          prdata,
  output logic                                 pready
);
  import tcsr_pkg::*;

  logic [VAL_W-1:0] target_r;
  logic             cfg_wr;
  cmd_t             cmd;
  sts_t             sts;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
    end else if (cfg_wr && paddr[2] == REG_TARGET_SUM) begin
      target_r <= pwdata[VAL_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_TARGET_SUM) ? APB_DW'(target_r) : '0;

  tcsr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .final_item (in_final_item),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy)
  );

  tcsr_datapath #(
    .MAX_ITEMS (MAX_ITEMS),
    .SUM_BITS  (SUM_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .first_value     (in_first_value),
    .second_value    (in_second_value),
    .final_item      (in_final_item),
    .target_sum      (target_r),
    .out_strobe      (out_strobe),
    .out_feasible    (out_feasible),
    .out_item_number (out_item_number),
    .out_took_second (out_took_second),
    .out_run_end     (out_run_end)
  );

  a_end_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_run_end |=> !out_strobe)
    else $error("result item right after the end of a run");

  a_fail_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_feasible |-> out_run_end && out_item_number == '0 && !out_took_second)
    else $error("malformed infeasible result");

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result item without preceding busy cycle");

endmodule

`default_nettype wire
